>>> rtl/tlpw_pkg.sv
package tlpw_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  // entry flag bits
  localparam int unsigned BIT_ACCESSED = 5;
  localparam int unsigned BIT_DIRTY    = 6;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_DATA      = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2
  } phase_t;

  // One queued request: a single memory read, or the closing triple
  // (directory write-back, table write-back, physical address).
  typedef struct packed {
    logic               triple;
    logic [ADDR_W-1:0]  addr0;
    logic [ADDR_W-1:0]  data0;
    logic [ADDR_W-1:0]  addr1;
    logic [ADDR_W-1:0]  data1;
    logic [ADDR_W-1:0]  addr2;
  } walk_entry_t;

endpackage

>>> rtl/tlpw_if.sv
interface tlpw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] virt_addr;
  logic        is_write;
  logic [31:0] mem_data;

  modport source (output valid, command, virt_addr, is_write, mem_data, input ready);
  modport sink   (input valid, command, virt_addr, is_write, mem_data, output ready);
endinterface

interface tlpw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] write_data;
  logic        last;

  modport source (output valid, kind, address, write_data, last, input ready);
  modport sink   (input valid, kind, address, write_data, last, output ready);
endinterface

interface tlpw_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/tlpw_front.sv
module tlpw_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  logic                                  command,
  input  logic [tlpw_pkg::ADDR_W-1:0]           virt_addr,
  input  logic                                  is_write,
  input  logic [tlpw_pkg::ADDR_W-1:0]           mem_data,
  input  logic [tlpw_pkg::FRAME_W-1:0]          dir_base_frame,
  output logic                                  push,
  output tlpw_pkg::walk_entry_t                 push_entry
);

  tlpw_pkg::phase_t                 phase_r, phase_nxt;
  logic [tlpw_pkg::ADDR_W-1:0]      va_r;
  logic                             wr_r;
  logic [tlpw_pkg::ADDR_W-1:0]      dir_addr_r;
  logic [tlpw_pkg::ADDR_W-1:0]      dir_word_r;
  logic [tlpw_pkg::ADDR_W-1:0]      tab_addr_r;

  logic [tlpw_pkg::ADDR_W-1:0]      dir_addr_new;
  logic [tlpw_pkg::ADDR_W-1:0]      tab_addr_new;
  logic [tlpw_pkg::ADDR_W-1:0]      pte_new;
  logic [tlpw_pkg::ADDR_W-1:0]      pa_new;

  // index fields never overlap the frame bits, so the sums are concatenations
  assign dir_addr_new = {dir_base_frame, virt_addr[31:22], 2'b00};
  assign tab_addr_new = {mem_data[31:12], va_r[21:12], 2'b00};
  assign pa_new       = {mem_data[31:12], va_r[11:0]};

  always_comb begin
    pte_new = mem_data;
    pte_new[tlpw_pkg::BIT_ACCESSED] = 1'b1;
    if (wr_r) begin
      pte_new[tlpw_pkg::BIT_DIRTY] = 1'b1;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (command == tlpw_pkg::CMD_TRANSLATE) begin
        phase_nxt = tlpw_pkg::PH_DIR;
      end else begin
        case (phase_r)
          tlpw_pkg::PH_DIR:   phase_nxt = tlpw_pkg::PH_TABLE;
          tlpw_pkg::PH_TABLE: phase_nxt = tlpw_pkg::PH_IDLE;
          default:            phase_nxt = tlpw_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // request generation
  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    if (acc) begin
      if (command == tlpw_pkg::CMD_TRANSLATE) begin
        push             = 1'b1;
        push_entry.addr0 = dir_addr_new;
      end else begin
        case (phase_r)
          tlpw_pkg::PH_DIR: begin
            push             = 1'b1;
            push_entry.addr0 = tab_addr_new;
          end
          tlpw_pkg::PH_TABLE: begin
            push              = 1'b1;
            push_entry.triple = 1'b1;
            push_entry.addr0  = dir_addr_r;
            push_entry.data0  = dir_word_r;
            push_entry.data0[tlpw_pkg::BIT_ACCESSED] = 1'b1;
            push_entry.addr1  = tab_addr_r;
            push_entry.data1  = pte_new;
            push_entry.addr2  = pa_new;
          end
          default: begin
            push = 1'b0;  // data with no walk open is dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlpw_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (command == tlpw_pkg::CMD_TRANSLATE) begin
        va_r       <= virt_addr;
        wr_r       <= is_write;
        dir_addr_r <= dir_addr_new;
      end else if (phase_r == tlpw_pkg::PH_DIR) begin
        dir_word_r <= mem_data;
        tab_addr_r <= tab_addr_new;
      end
    end
  end

endmodule

>>> rtl/tlpw_queue.sv
module tlpw_queue #(
  parameter int unsigned DEPTH = tlpw_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tlpw_pkg::walk_entry_t  push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output tlpw_pkg::walk_entry_t  head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tlpw_pkg::walk_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tlpw_back.sv
module tlpw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  tlpw_pkg::walk_entry_t         head_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlpw_pkg::kind_t               out_kind,
  output logic [tlpw_pkg::ADDR_W-1:0]   out_address,
  output logic [tlpw_pkg::ADDR_W-1:0]   out_write_data,
  output logic                          out_last
);

  logic [1:0] beat_r, beat_nxt;
  logic       fire;

  assign out_valid = head_valid;
  assign fire      = head_valid && out_ready;
  assign pop       = fire && out_last;

  always_comb begin
    out_kind       = tlpw_pkg::KIND_READ;
    out_address    = head_entry.addr0;
    out_write_data = '0;
    out_last       = 1'b1;
    if (head_entry.triple) begin
      case (beat_r)
        2'd0: begin
          out_kind       = tlpw_pkg::KIND_WRITE;
          out_write_data = head_entry.data0;
          out_last       = 1'b0;
        end
        2'd1: begin
          out_kind       = tlpw_pkg::KIND_WRITE;
          out_address    = head_entry.addr1;
          out_write_data = head_entry.data1;
          out_last       = 1'b0;
        end
        default: begin
          out_kind    = tlpw_pkg::KIND_DONE;
          out_address = head_entry.addr2;
        end
      endcase
    end
  end

  always_comb begin
    beat_nxt = beat_r;
    if (fire) begin
      beat_nxt = out_last ? 2'd0 : beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= 2'd0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

endmodule

>>> rtl/two_level_page_table_walker_core.sv
// Two-level page table walker, 32-bit virtual addresses, 4 KiB pages.
// in_chan   : requests. command 0 starts a translation (virt_addr, is_write);
//             command 1 returns a page table word on mem_data.
// out_chan  : results. kind 0 = memory read, 1 = memory write, 2 = done.
//             last marks the final result of one input request.
// cfg_chan  : directory base frame (20 bits); always ready. Write it only
//             while no walk is open.
// A translate gives one directory read; the directory word gives one table
// read; the table word gives two write-backs (accessed, dirty on writes)
// and the physical address. A translate abandons any open walk; data with
// no walk open is taken and dropped.
// Results are registered in the result queue: the first result of an accepted
// input is visible the cycle after, once the results queued ahead of it have left.
// Throughput: one input per cycle for single-result requests while the queue is
// not full; the closing triple occupies the output for three results. A small
// result queue (QUEUE_DEPTH entries) sits between the walk logic and the output
// sequencer, so in_ready only drops while that queue is full. When out_ready is
// low, results hold and the queue fills, then in_ready drops. Reset (rst_n low,
// synchronous) empties the queue, closes any walk and clears the base frame to zero.
module two_level_page_table_walker_core #(
  parameter int unsigned QUEUE_DEPTH = tlpw_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  tlpw_in_if.sink     in_chan,
  tlpw_out_if.source  out_chan,
  tlpw_cfg_if.sink    cfg_chan
);

  logic [tlpw_pkg::FRAME_W-1:0] dir_base_frame_r;

  logic                  in_acc;
  logic                  q_full;
  logic                  push;
  tlpw_pkg::walk_entry_t push_entry;
  logic                  pop;
  logic                  head_valid;
  tlpw_pkg::walk_entry_t head_entry;
  tlpw_pkg::kind_t       out_kind;

  // config register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_frame_r <= '0;
    end else if (cfg_chan.valid) begin
      dir_base_frame_r <= cfg_chan.data;
    end
  end

  // input side stalls only on a full queue
  assign in_chan.ready = !q_full;
  assign in_acc        = in_chan.valid && !q_full;

  tlpw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .command        (in_chan.command),
    .virt_addr      (in_chan.virt_addr),
    .is_write       (in_chan.is_write),
    .mem_data       (in_chan.mem_data),
    .dir_base_frame (dir_base_frame_r),
    .push           (push),
    .push_entry     (push_entry)
  );

  tlpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  tlpw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_kind       (out_kind),
    .out_address    (out_chan.address),
    .out_write_data (out_chan.write_data),
    .out_last       (out_chan.last)
  );

  assign out_chan.kind = out_kind;

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpw_pkg::*;

  // Hard stop, far above the slowest legal run (about 230 requests, up to 350
  // results, with random stall bursts on both sides).
  localparam int CYCLE_LIMIT = 200000;
  // Results trail acceptance through the small result queue; data sent with
  // no walk open produces nothing, so give it time to settle.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        command;
    logic [31:0] virt_addr;
    logic        is_write;
    logic [31:0] mem_data;
  } walk_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        last;
  } walk_res_t;

  logic clk = 1'b0;
  logic rst_n;

  tlpw_in_if  in_if ();
  tlpw_out_if out_if ();
  tlpw_cfg_if cfg_if ();

  two_level_page_table_walker_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests waiting to be driven, and results the walk is still owed.
  walk_req_t walk_reqs_pending[$];
  walk_res_t walk_results_due[$];

  // Shadow of the walker state, advanced on every accepted request.
  logic [19:0] shadow_dir_base;
  phase_t      shadow_phase;
  logic [31:0] shadow_va;
  logic        shadow_write;
  logic [31:0] shadow_dir_addr;
  logic [31:0] shadow_dir_word;
  logic [31:0] shadow_tbl_addr;

  int  mismatches;
  bit  gaps_on;      // random idling on both channels
  int  in_gap;       // cycles left in the current request-side idle burst
  int  out_gap;      // cycles left in the current result-side stall
  bit  in_fire;      // request accepted at the last rising edge
  walk_req_t in_item;

  // Stimulus-side view of the walk, so phases never end with a walk open.
  int  gen_step;

  // Computes what one accepted request should produce.
  function automatic void walk_predict(input walk_req_t req);
    logic [31:0] pte;
    if (req.command == CMD_TRANSLATE) begin
      // A translate always starts over, abandoning any open walk.
      shadow_va       = req.virt_addr;
      shadow_write    = req.is_write;
      shadow_dir_addr = {shadow_dir_base, 12'h000} + {20'h0, req.virt_addr[31:22], 2'b00};
      shadow_phase    = PH_DIR;
      walk_results_due.push_back('{KIND_READ, shadow_dir_addr, 32'h0, 1'b1});
    end else if (shadow_phase == PH_DIR) begin
      shadow_dir_word = req.mem_data;
      shadow_tbl_addr = {req.mem_data[31:12], 12'h000} + {20'h0, shadow_va[21:12], 2'b00};
      shadow_phase    = PH_TABLE;
      walk_results_due.push_back('{KIND_READ, shadow_tbl_addr, 32'h0, 1'b1});
    end else if (shadow_phase == PH_TABLE) begin
      pte = req.mem_data;
      pte[BIT_ACCESSED] = 1'b1;
      if (shadow_write) begin
        pte[BIT_DIRTY] = 1'b1;
      end
      walk_results_due.push_back('{KIND_WRITE, shadow_dir_addr,
                                   shadow_dir_word | (32'h1 << BIT_ACCESSED), 1'b0});
      walk_results_due.push_back('{KIND_WRITE, shadow_tbl_addr, pte, 1'b0});
      walk_results_due.push_back('{KIND_DONE, {req.mem_data[31:12], shadow_va[11:0]},
                                   32'h0, 1'b1});
      shadow_phase = PH_IDLE;
    end
    // Data with no walk open is dropped by the block: nothing expected.
  endfunction

  // Monitor: everything sampled at the rising edge, in one process, so the
  // shadow state and the result check always see a consistent picture.
  always @(posedge clk) begin
    walk_res_t want;
    in_fire <= in_if.valid && in_if.ready;
    if (!rst_n) begin
      shadow_dir_base = '0;
      shadow_phase    = PH_IDLE;
      shadow_va       = '0;
      shadow_write    = 1'b0;
      shadow_dir_addr = '0;
      shadow_dir_word = '0;
      shadow_tbl_addr = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        shadow_dir_base = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) begin
        walk_predict('{in_if.command, in_if.virt_addr, in_if.is_write, in_if.mem_data});
      end
      if (out_if.valid && out_if.ready) begin
        if (walk_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind=%0d addr=%h data=%h last=%b",
                     out_if.kind, out_if.address, out_if.write_data, out_if.last);
          end
        end else begin
          want = walk_results_due.pop_front();
          if (out_if.kind !== want.kind || out_if.address !== want.address ||
              out_if.write_data !== want.write_data || out_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind=%0d addr=%h data=%h last=%b",
                       want.kind, want.address, want.write_data, want.last);
              $display("                 actual   kind=%0d addr=%h data=%h last=%b",
                       out_if.kind, out_if.address, out_if.write_data, out_if.last);
            end
          end
        end
      end
    end
  end

  // Request driver: a presented request holds until taken, idle bursts only
  // start between requests.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_if.valid && !in_fire)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (walk_reqs_pending.size() != 0) begin
          if (gaps_on && $urandom_range(0, 11) == 0) begin
            in_gap = $urandom_range(0, 18);
            in_if.valid <= 1'b0;
          end else begin
            in_item = walk_reqs_pending.pop_front();
            in_if.command   <= in_item.command;
            in_if.virt_addr <= in_item.virt_addr;
            in_if.is_write  <= in_item.is_write;
            in_if.mem_data  <= in_item.mem_data;
            in_if.valid     <= 1'b1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result-side back-pressure in bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap != 0) begin
        out_gap--;
      end else if (gaps_on && $urandom_range(0, 13) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_translate(input logic [31:0] va, input logic wr);
    walk_reqs_pending.push_back('{CMD_TRANSLATE, va, wr, $urandom});
    gen_step = 1;
  endtask

  task automatic push_data(input logic [31:0] md);
    walk_reqs_pending.push_back('{CMD_DATA, $urandom, 1'($urandom_range(0, 1)), md});
    gen_step = (gen_step == 1) ? 2 : 0;
  endtask

  // Directory base is only written with the walker idle and no walk open.
  task automatic set_dir_base(input logic [19:0] frame);
    @(negedge clk);
    cfg_if.data  <= frame;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Finish any open walk, then wait until every request is taken and every
  // owed result has come back.
  task automatic drain_walks();
    while (gen_step != 0) push_data($urandom);
    while (walk_reqs_pending.size() != 0 || in_if.valid || walk_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete walks with random content; the rest abandoned walks and
  // stray data. Stray data that the block drops is not counted.
  task automatic random_walks(input int count);
    int done_cnt;
    int pick;
    done_cnt = 0;
    while (done_cnt < count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        push_translate($urandom, 1'($urandom_range(0, 1)));
        push_data($urandom);
        push_data($urandom);
        done_cnt += 3;
      end else if (pick == 7) begin
        if (gen_step != 0) begin
          done_cnt++;
        end
        push_data($urandom);
      end else if (pick == 8) begin
        push_translate($urandom, 1'($urandom_range(0, 1)));
        done_cnt++;
      end else begin
        push_translate($urandom, 1'($urandom_range(0, 1)));
        push_data($urandom);
        done_cnt += 2;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_TRANSLATE;
    in_if.virt_addr  = '0;
    in_if.is_write   = 1'b0;
    in_if.mem_data   = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    mismatches       = 0;
    in_gap           = 0;
    out_gap          = 0;
    in_fire          = 1'b0;
    gen_step         = 0;
    gaps_on          = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Top directory frame: all-ones addresses and words, both flags.
    set_dir_base(20'hFFFFF);
    push_translate(32'hFFFFFFFF, 1'b1);
    push_data(32'hFFFFFFFF);
    push_data(32'hFFFFFFFF);
    push_translate(32'h00000000, 1'b0);
    push_data(32'h00000000);
    push_data(32'h00000000);
    // data with no walk open is dropped
    push_data(32'h12345678);
    // new translate while waiting for the directory word
    push_translate(32'hABCDE123, 1'b1);
    push_translate(32'h55555555, 1'b0);
    push_data(32'hFFFFF9DF);
    // new translate while waiting for the table word
    push_translate(32'hAAAAAAAA, 1'b1);
    push_data(32'h00001000);
    push_data(32'h000FFF9F);
    push_data(32'hDEADBEEF);
    push_data(32'h00000060);
    drain_walks();

    // Directory at frame zero; flags already set in the first walk's words, missing in the second's.
    set_dir_base(20'h00000);
    push_translate(32'hFFFFF000, 1'b0);
    push_data(32'h00000FFF);
    push_data(32'hFFFFF060);
    push_translate(32'h003FFFFF, 1'b1);
    push_data(32'h80000000);
    push_data(32'h7FFFFFBF);
    drain_walks();

    // Random phases; the last one runs with no idling at all.
    for (int p = 0; p < 4; p++) begin
      gaps_on = (p != 3);
      set_dir_base((p == 1) ? 20'hFFFFF : 20'($urandom));
      random_walks(50);
      drain_walks();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && walk_results_due.size() == 0) begin
      $display("[two_level_page_table_walker_core] OK");
    end else begin
      $display("[two_level_page_table_walker_core] ERROR");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("[two_level_page_table_walker_core] ERROR");
    $finish;
  end

endmodule
